// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/kcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// kcbf_pkg
// Types, codes and defaults shared by the key colour box finder modules.
// ----------------------------------------------------------------------------
package kcbf_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int MAX_BOXES_DEF  = 64;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 80;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_DAT_W-1:0] DIM_RESET        = 10'd512;

    localparam logic [7:0] KEY_FULL  = 8'hff;
    localparam logic [7:0] KEY_EMPTY = 8'h00;

    localparam logic [1:0] CLASS_OTHER = 2'd0;
    localparam logic [1:0] CLASS_FRAME = 2'd1;
    localparam logic [1:0] CLASS_HOT   = 2'd2;

    localparam logic signed [9:0] HOT_NONE = -10'sd2;

    // store address source for a scan read
    typedef enum logic [2:0] {
        ADDR_CUR,
        ADDR_RIGHT,
        ADDR_DOWN,
        ADDR_PTR_R,
        ADDR_PTR_D
    } addr_sel_t;

    typedef struct packed {
        logic      load_wr;
        logic      scan_init;
        logic      rd_en;
        addr_sel_t rd_src;
        logic      rw_init;
        logic      rw_step;
        logic      rh_init;
        logic      rh_step;
        logic      box_push;
        logic      ovf_set;
        logic      fin_push;
        logic      adv;
    } kcbf_cmd_t;

    typedef struct packed {
        logic marked;
        logic hot;
        logic right_ok;
        logic down_ok;
        logic rw_more;
        logic rh_more;
        logic count_full;
        logic out_free;
        logic pend_valid;
        logic scan_done;
    } kcbf_stat_t;

    typedef struct packed {
        logic               last_box;
        logic               box_overflow;
        logic signed [9:0]  hotspot_y;
        logic signed [9:0]  hotspot_x;
        logic [8:0]         inner_height;
        logic [8:0]         inner_width;
        logic [8:0]         corner_y;
        logic [8:0]         corner_x;
        logic [15:0]        sprite_number;
        logic               box_found;
    } box_t;

endpackage

// ===== src/kcbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcbf_ctrl
// Sequencer: pixel load, raster scan, run walks and result hand-off.
// ----------------------------------------------------------------------------
module kcbf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tlast,
    output logic                s_axis_tready,
    output kcbf_pkg::kcbf_cmd_t cmd,
    input  kcbf_pkg::kcbf_stat_t stat
);
    import kcbf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RC,
        S_EC,
        S_ER,
        S_ED,
        S_RW,
        S_RH,
        S_EMIT,
        S_NEXT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // decode commands and next state
    always_comb
    begin
        cmd        = '0;
        cmd.rd_src = ADDR_CUR;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load_wr = 1'b1;
                    if (s_axis_tlast)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_RC;
                    end
                end
            end
            S_RC:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = ADDR_CUR;
                state_next = S_EC;
            end
            S_EC:
            begin
                if (stat.marked && stat.right_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = ADDR_RIGHT;
                    state_next = S_ER;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_ER:
            begin
                if (stat.marked && stat.down_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = ADDR_DOWN;
                    state_next = S_ED;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_ED:
            begin
                if (!stat.marked)
                begin
                    state_next = S_NEXT;
                end
                else if (stat.count_full)
                begin
                    cmd.ovf_set = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rw_init = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_src  = ADDR_CUR;
                    state_next  = S_RW;
                end
            end
            S_RW:
            begin
                if (stat.marked)
                begin
                    cmd.rw_step = 1'b1;
                end
                if (stat.marked && stat.rw_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = ADDR_PTR_R;
                end
                else
                begin
                    cmd.rh_init = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_src  = ADDR_DOWN;
                    state_next  = S_RH;
                end
            end
            S_RH:
            begin
                if (stat.marked)
                begin
                    cmd.rh_step = 1'b1;
                end
                if (stat.marked && stat.rh_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = ADDR_PTR_D;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.box_push = 1'b1;
                    state_next   = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_RC;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/kcbf_dpath.sv =====
// ----------------------------------------------------------------------------
// kcbf_dpath
// Class store, scan counters, run walkers, pending box and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kcbf_dpath
#(
    parameter int MaxWidth  = kcbf_pkg::MAX_WIDTH_DEF,
    parameter int MaxHeight = kcbf_pkg::MAX_HEIGHT_DEF,
    parameter int MaxBoxes  = kcbf_pkg::MAX_BOXES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [kcbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcbf_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic [kcbf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kcbf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    input  kcbf_pkg::kcbf_cmd_t              cmd,
    output kcbf_pkg::kcbf_stat_t             stat
);
    import kcbf_pkg::*;

    localparam int StoreSize = MaxWidth * MaxHeight;
    localparam int AW = $clog2(StoreSize);
    localparam int PW = $clog2(StoreSize + 1);
    localparam int XW = $clog2(MaxWidth + 1);
    localparam int YW = $clog2(MaxHeight + 1);
    localparam int CW = $clog2(MaxBoxes + 1);

    logic [CFG_DAT_W-1:0] wcfg_reg;
    logic [CFG_DAT_W-1:0] hcfg_reg;
    logic [XW-1:0]        w_eff;
    logic [YW-1:0]        h_eff;

    logic [1:0]           class_mem [StoreSize];
    logic [1:0]           rd_reg;
    logic [PW-1:0]        pos_reg;
    logic [1:0]           pix_class;

    logic [XW-1:0]        x_reg;
    logic [YW-1:0]        y_reg;
    logic [AW-1:0]        row_base_reg;
    logic [AW-1:0]        ptr_reg;
    logic [AW-1:0]        addr_cur;
    logic [AW-1:0]        rd_addr;
    logic [XW-1:0]        rw_reg;
    logic [YW-1:0]        rh_reg;
    logic signed [9:0]    hx_reg;
    logic signed [9:0]    hy_reg;
    logic [CW-1:0]        count_reg;
    logic                 ovf_reg;
    logic [15:0]          sprite_reg;
    logic [15:0]          sprite_next;

    box_t                 pend_reg;
    logic                 pend_valid_reg;
    box_t                 out_reg;
    logic                 out_valid_reg;
    box_t                 new_box;
    box_t                 fin_box;
    logic                 out_free;
    logic                 out_load;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcfg_reg <= DIM_RESET;
            hcfg_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                wcfg_reg <= cfg_data;
            end
            else if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                hcfg_reg <= cfg_data;
            end
        end
    end

    // clamp dimensions to the store shape
    always_comb
    begin
        if (wcfg_reg == '0)
        begin
            w_eff = XW'(1);
        end
        else if (16'(wcfg_reg) > 16'(MaxWidth))
        begin
            w_eff = XW'(MaxWidth);
        end
        else
        begin
            w_eff = XW'(wcfg_reg);
        end
        if (hcfg_reg == '0)
        begin
            h_eff = YW'(1);
        end
        else if (16'(hcfg_reg) > 16'(MaxHeight))
        begin
            h_eff = YW'(MaxHeight);
        end
        else
        begin
            h_eff = YW'(hcfg_reg);
        end
    end

    // classify the incoming pixel
    always_comb
    begin
        priority if (s_axis_tdata[7:0] == KEY_FULL && s_axis_tdata[15:8] == KEY_EMPTY
                     && s_axis_tdata[23:16] == KEY_FULL)
        begin
            pix_class = CLASS_FRAME;
        end
        else if (s_axis_tdata[7:0] == KEY_EMPTY && s_axis_tdata[15:8] == KEY_FULL
                 && s_axis_tdata[23:16] == KEY_EMPTY)
        begin
            pix_class = CLASS_HOT;
        end
        else
        begin
            pix_class = CLASS_OTHER;
        end
    end

    // select the scan read address
    assign addr_cur = row_base_reg + AW'(x_reg);
    always_comb
    begin
        unique case (cmd.rd_src)
            ADDR_CUR:   rd_addr = addr_cur;
            ADDR_RIGHT: rd_addr = addr_cur + AW'(1);
            ADDR_DOWN:  rd_addr = addr_cur + AW'(w_eff);
            ADDR_PTR_R: rd_addr = ptr_reg + AW'(1);
            ADDR_PTR_D: rd_addr = ptr_reg + AW'(w_eff);
            default:    rd_addr = addr_cur;
        endcase
    end

    // write loaded pixels, read during the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && (pos_reg < PW'(StoreSize)))
        begin
            class_mem[pos_reg[AW-1:0]] <= pix_class;
        end
        if (cmd.rd_en)
        begin
            rd_reg  <= class_mem[rd_addr];
            ptr_reg <= rd_addr;
        end
    end

    // advance load position, saturate at capacity, return to zero on the final pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.load_wr)
        begin
            if (s_axis_tlast)
            begin
                pos_reg <= '0;
            end
            else if (pos_reg < PW'(StoreSize))
            begin
                pos_reg <= pos_reg + PW'(1);
            end
        end
    end

    // scan position and run walkers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            row_base_reg <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            sprite_reg   <= '0;
        end
        else
        begin
            if (cmd.scan_init)
            begin
                x_reg        <= '0;
                y_reg        <= '0;
                row_base_reg <= '0;
                count_reg    <= '0;
                ovf_reg      <= 1'b0;
            end
            if (cmd.adv)
            begin
                if (stat.right_ok)
                begin
                    x_reg <= x_reg + XW'(1);
                end
                else
                begin
                    x_reg        <= '0;
                    y_reg        <= y_reg + YW'(1);
                    row_base_reg <= row_base_reg + AW'(w_eff);
                end
            end
            if (cmd.ovf_set)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.box_push)
            begin
                count_reg  <= count_reg + CW'(1);
                sprite_reg <= sprite_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rw_init)
        begin
            rw_reg <= '0;
            hx_reg <= HOT_NONE;
        end
        else if (cmd.rw_step)
        begin
            rw_reg <= rw_reg + XW'(1);
            if (rd_reg == CLASS_HOT)
            begin
                hx_reg <= 10'(rw_reg) - 10'sd1;
            end
        end
        if (cmd.rh_init)
        begin
            rh_reg <= YW'(1);
            hy_reg <= HOT_NONE;
        end
        else if (cmd.rh_step)
        begin
            rh_reg <= rh_reg + YW'(1);
            if (rd_reg == CLASS_HOT)
            begin
                hy_reg <= 10'(rh_reg) - 10'sd1;
            end
        end
    end

    assign sprite_next = sprite_reg + 16'd1;

    // assemble results
    always_comb
    begin
        new_box               = '0;
        new_box.box_found     = 1'b1;
        new_box.sprite_number = sprite_next;
        new_box.corner_x      = 9'(x_reg);
        new_box.corner_y      = 9'(y_reg);
        new_box.inner_width   = 9'(rw_reg - XW'(2));
        new_box.inner_height  = 9'(rh_reg - YW'(2));
        new_box.hotspot_x     = hx_reg;
        new_box.hotspot_y     = hy_reg;

        fin_box = '0;
        if (pend_valid_reg)
        begin
            fin_box              = pend_reg;
            fin_box.box_overflow = ovf_reg;
        end
        fin_box.last_box = 1'b1;
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = cmd.fin_push || (cmd.box_push && pend_valid_reg);

    // pending box and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.scan_init || cmd.fin_push)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.box_push)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.box_push)
        begin
            pend_reg <= new_box;
        end
        if (cmd.fin_push)
        begin
            out_reg <= fin_box;
        end
        else if (cmd.box_push && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.box_found;
    assign m_axis_tlast  = out_reg.last_box;
    assign m_axis_tdata  = {7'd0, out_reg.box_overflow, out_reg.hotspot_y, out_reg.hotspot_x,
                            out_reg.inner_height, out_reg.inner_width, out_reg.corner_y,
                            out_reg.corner_x, out_reg.sprite_number};

    // status to the sequencer
    always_comb
    begin
        stat            = '0;
        stat.marked     = (rd_reg != CLASS_OTHER);
        stat.hot        = (rd_reg == CLASS_HOT);
        stat.right_ok   = ({1'b0, x_reg} + (XW + 1)'(1)) < {1'b0, w_eff};
        stat.down_ok    = ({1'b0, y_reg} + (YW + 1)'(1)) < {1'b0, h_eff};
        stat.rw_more    = ({1'b0, x_reg} + {1'b0, rw_reg} + (XW + 1)'(1)) < {1'b0, w_eff};
        stat.rh_more    = ({1'b0, y_reg} + {1'b0, rh_reg} + (YW + 1)'(1)) < {1'b0, h_eff};
        stat.count_full = (count_reg >= CW'(MaxBoxes));
        stat.out_free   = out_free;
        stat.pend_valid = pend_valid_reg;
        stat.scan_done  = !stat.right_ok && !stat.down_ok;
    end

    `ASSERT_HOLDS(a_count_bound, count_reg <= CW'(MaxBoxes))
    `ASSERT_NEXT(a_scan_clears, cmd.scan_init, !pend_valid_reg && count_reg == '0)
    `ASSERT_IMPLIES(a_no_overwrite, out_load && out_valid_reg, m_axis_tready)

endmodule

// ===== src/key_color_box_finder_top.sv =====
// ----------------------------------------------------------------------------
// key_color_box_finder_top
// Key colour box finder: loads an image, then reports frame boxes.
// ----------------------------------------------------------------------------
// Pixels arrive on the s_axis channel, one request per pixel in raster order,
// blue/green/red in tdata and tlast on the final pixel. After the final pixel
// the block scans the stored class map and accepts no pixel until the scan
// has finished and its final result is in the output register.
// Each result request on m_axis describes one box (tuser high) or, for an
// image without boxes, a single empty result; tlast marks the final one.
// The first box is reported once the second is found or the scan ends, and
// each result is handed over through a single output register: a stalled
// receiver halts the scan at the next box. The class store has one read port.
// Configuration writes (image width, image height) are taken in any cycle
// and are meant to happen only while the block is idle.
// Reset clears the sprite count, load position and dimensions (512 x 512);
// the class store is not cleared.
// ----------------------------------------------------------------------------
module key_color_box_finder_top
#(
    parameter int MAX_WIDTH  = kcbf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = kcbf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_BOXES  = kcbf_pkg::MAX_BOXES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kcbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kcbf_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // blue [7:0], green [15:8], red [23:16]
    input  logic [kcbf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sprite_number [15:0], corner_x [24:16], corner_y [33:25],
    // inner_width [42:34], inner_height [51:43], hotspot_x [61:52],
    // hotspot_y [71:62], box_overflow [72], zero [79:73]
    output logic [kcbf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // box_found
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import kcbf_pkg::*;

    kcbf_cmd_t  cmd;
    kcbf_stat_t stat;

    assign cfg_ready = 1'b1;

    kcbf_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .stat          (stat)
    );

    kcbf_dpath
    #(
        .MaxWidth  (MAX_WIDTH),
        .MaxHeight (MAX_HEIGHT),
        .MaxBoxes  (MAX_BOXES)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ===== dv/tb_key_color_box_finder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_color_box_finder_top
// Self-checking bench for the key colour box finder. Images of random and
// drawn content are streamed in; a predictor in the bench classifies each
// pixel, scans its own class map on the final pixel and queues the expected
// box results, which are compared with every result request on m_axis.
// ----------------------------------------------------------------------------
module tb_key_color_box_finder_top;
    import kcbf_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT = 900000;
    localparam logic [23:0] PIX_FRAME = {KEY_FULL, KEY_EMPTY, KEY_FULL};
    localparam logic [23:0] PIX_HOT   = {KEY_EMPTY, KEY_FULL, KEY_EMPTY};
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    // predictor state
    logic [1:0]  class_map [STORE_DEPTH];
    int          load_pos;
    int          loaded_top;
    logic [15:0] sprite_count;
    logic [9:0]  width_reg;
    logic [9:0]  height_reg;
    box_t        boxes_due [$];

    // stimulus control
    logic [23:0] pix_buf [$];
    int          send_idle;
    int          recv_idle;
    int          hold_req;
    int          hold_cnt;
    int          mismatches;
    int          cycles;

    key_color_box_finder_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("key_color_box_finder_top test failed");
            $finish;
        end
    end

    function automatic int clamp_dim(logic [9:0] v);
        if (v < 10'd1)
            return 1;
        if (v > 10'd512)
            return 512;
        return int'(v);
    endfunction

    function automatic logic [1:0] class_of(logic [23:0] pix);
        if (pix == PIX_FRAME)
            return CLASS_FRAME;
        if (pix == PIX_HOT)
            return CLASS_HOT;
        return CLASS_OTHER;
    endfunction

    function automatic logic [1:0] class_at(int x, int y, int w, int h);
        if (x >= w || y >= h)
            return CLASS_OTHER;
        return class_map[y * w + x];
    endfunction

    function automatic bit marked_at(int x, int y, int w, int h);
        return class_at(x, y, w, h) != CLASS_OTHER;
    endfunction

    // scan the class map and queue one result per box, or one empty result if none
    task automatic scan_for_boxes();
        int   w;
        int   h;
        int   found;
        int   run_w;
        int   run_h;
        bit   ovf;
        box_t b;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        found = 0;
        ovf = 1'b0;
        for (int y = 0; y < h && !ovf; y++)
        begin
            for (int x = 0; x < w && !ovf; x++)
            begin
                if (!(marked_at(x, y, w, h) && marked_at(x + 1, y, w, h)
                      && marked_at(x, y + 1, w, h)))
                    continue;
                if (found >= MAX_BOXES_DEF)
                begin
                    ovf = 1'b1;
                    break;
                end
                b = '0;
                b.hotspot_x = HOT_NONE;
                b.hotspot_y = HOT_NONE;
                run_w = 0;
                while (x + run_w < w && marked_at(x + run_w, y, w, h))
                begin
                    if (class_at(x + run_w, y, w, h) == CLASS_HOT)
                        b.hotspot_x = 10'(run_w - 1);
                    run_w++;
                end
                run_h = 1;
                while (y + run_h < h && marked_at(x, y + run_h, w, h))
                begin
                    if (class_at(x, y + run_h, w, h) == CLASS_HOT)
                        b.hotspot_y = 10'(run_h - 1);
                    run_h++;
                end
                sprite_count = sprite_count + 16'd1;
                b.box_found     = 1'b1;
                b.sprite_number = sprite_count;
                b.corner_x      = 9'(x);
                b.corner_y      = 9'(y);
                b.inner_width   = 9'(run_w - 2);
                b.inner_height  = 9'(run_h - 2);
                boxes_due.push_back(b);
                found++;
            end
        end
        if (found == 0)
        begin
            b = '0;
            b.last_box = 1'b1;
            boxes_due.push_back(b);
        end
        else
        begin
            boxes_due[$].box_overflow = ovf;
            boxes_due[$].last_box = 1'b1;
        end
    endtask

    // write one register; the block is idle whenever this is called
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = val;
        @(posedge clk);
    endtask

    task automatic set_dims(logic [9:0] w, logic [9:0] h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // send one pixel request and update the predictor when it is taken
    task automatic send_pixel(logic [23:0] pix, bit last);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (load_pos < STORE_DEPTH)
        begin
            class_map[load_pos] = class_of(pix);
            load_pos++;
            if (load_pos > loaded_top)
                loaded_top = load_pos;
        end
        if (last)
        begin
            scan_for_boxes();
            load_pos = 0;
        end
    endtask

    // stream pix_buf; count may run past the buffer with random pixels
    task automatic send_image(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i < pix_buf.size())
                send_pixel(pix_buf[i], i == count - 1);
            else
                send_pixel(24'($urandom), i == count - 1);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // hold until every expected result is in, then let the block settle
    task automatic wait_drained();
        while (boxes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [23:0] random_pixel(int pct_frame, int pct_hot);
        int r;
        r = $urandom_range(99);
        if (r < pct_frame)
            return PIX_FRAME;
        if (r < pct_frame + pct_hot)
            return PIX_HOT;
        // near misses of the key colours now and then
        if (r < pct_frame + pct_hot + 10)
            return ($urandom_range(1) ? PIX_FRAME : PIX_HOT) ^ (24'd1 << $urandom_range(23));
        return 24'($urandom);
    endfunction

    task automatic fill_buf(int w, int h, int pct_frame, int pct_hot);
        pix_buf.delete();
        for (int i = 0; i < w * h; i++)
            pix_buf.push_back(random_pixel(pct_frame, pct_hot));
    endtask

    // draw a frame outline with optional hotspots on its top and left runs
    task automatic draw_box(int w, int x0, int y0, int bw, int bh);
        for (int i = 0; i < bw; i++)
        begin
            pix_buf[y0 * w + x0 + i] = PIX_FRAME;
            pix_buf[(y0 + bh - 1) * w + x0 + i] = PIX_FRAME;
        end
        for (int j = 0; j < bh; j++)
        begin
            pix_buf[(y0 + j) * w + x0] = PIX_FRAME;
            pix_buf[(y0 + j) * w + x0 + bw - 1] = PIX_FRAME;
        end
        if ($urandom_range(2) != 0)
            pix_buf[y0 * w + x0 + $urandom_range(bw - 1)] = PIX_HOT;
        if ($urandom_range(2) != 0)
            pix_buf[(y0 + $urandom_range(bh - 1)) * w + x0] = PIX_HOT;
    endtask

    // result receiver with random stalls and long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // compare each result request with the oldest expected box
    always @(posedge clk)
    begin
        box_t got;
        box_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.box_found     = m_axis_tuser;
            got.sprite_number = m_axis_tdata[15:0];
            got.corner_x      = m_axis_tdata[24:16];
            got.corner_y      = m_axis_tdata[33:25];
            got.inner_width   = m_axis_tdata[42:34];
            got.inner_height  = m_axis_tdata[51:43];
            got.hotspot_x     = m_axis_tdata[61:52];
            got.hotspot_y     = m_axis_tdata[71:62];
            got.box_overflow  = m_axis_tdata[72];
            got.last_box      = m_axis_tlast;
            if (boxes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = boxes_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic test_empty_image();
        set_dims(10'd3, 10'd2);
        fill_buf(3, 2, 0, 0);
        send_image(6);
        wait_drained();
    endtask

    task automatic test_single_box();
        set_dims(10'd6, 10'd5);
        fill_buf(6, 5, 0, 0);
        draw_box(6, 1, 0, 5, 4);
        pix_buf[0 * 6 + 1] = PIX_HOT;
        pix_buf[3 * 6 + 1] = PIX_HOT;
        send_image(30);
        wait_drained();
        // hotspot in the corner, more pixels than the image holds
        draw_box(6, 0, 1, 4, 4);
        pix_buf[6] = PIX_HOT;
        send_image(33);
        wait_drained();
        // short image: the tail keeps its older contents
        send_image(20);
        wait_drained();
    endtask

    task automatic test_box_overflow();
        set_dims(10'd10, 10'd10);
        fill_buf(10, 10, 100, 0);
        send_image(100);
        wait_drained();
    endtask

    task automatic test_extreme_dims();
        // zero width clamps to a single column
        set_dims(10'd0, 10'd3);
        fill_buf(1, 3, 100, 0);
        send_image(3);
        wait_drained();
        // zero height clamps to a single row
        set_dims(10'd3, 10'd0);
        fill_buf(3, 1, 100, 0);
        send_image(3);
        wait_drained();
        // single column, and a write to a register that does not exist
        write_reg(REG_UNUSED, 10'd5);
        set_dims(10'd1, 10'd4);
        fill_buf(1, 4, 100, 0);
        send_image(4);
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_dims(10'd7, 10'd7);
        fill_buf(7, 7, 80, 10);
        hold_req = 600;
        send_image(49);
        fill_buf(7, 7, 70, 10);
        send_image(49);
        wait_drained();
    endtask

    task automatic test_random_images();
        int sent;
        int w;
        int h;
        int n;
        sent = 0;
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 25 : (mode == 1) ? 51 : 0;
            recv_idle = (mode == 0) ? 51 : (mode == 1) ? 25 : 0;
            while (sent < (mode + 1) * 10)
            begin
                w = $urandom_range(2, 9);
                h = $urandom_range(2, 9);
                set_dims(10'(w), 10'(h));
                if ($urandom_range(9) < 7)
                begin
                    fill_buf(w, h, 5, 2);
                    for (int k = $urandom_range(1, 2); k > 0; k--)
                    begin
                        int bw;
                        int bh;
                        bw = $urandom_range(2, w);
                        bh = $urandom_range(2, h);
                        draw_box(w, $urandom_range(w - bw), $urandom_range(h - bh), bw, bh);
                    end
                end
                else
                    fill_buf(w, h, 45, 15);
                n = w * h;
                if ($urandom_range(9) == 0)
                    n = n + $urandom_range(1, 4);
                else if ($urandom_range(9) == 0 && loaded_top >= w * h)
                    n = $urandom_range(1, w * h);
                send_image(n);
                sent += n;
                wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        load_pos      = 0;
        loaded_top    = 0;
        sprite_count  = '0;
        width_reg     = DIM_RESET;
        height_reg    = DIM_RESET;
        send_idle     = 25;
        recv_idle     = 51;
        hold_req      = 0;
        hold_cnt      = 0;
        mismatches    = 0;
        cycles        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_image();
        test_single_box();
        test_box_overflow();
        test_extreme_dims();
        test_backpressure();
        test_random_images();

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && boxes_due.size() == 0)
            $display("key_color_box_finder_top test passed");
        else
            $display("key_color_box_finder_top test failed");
        $finish;
    end

endmodule
